[hdl/thavg_pkg.sv]
// Shared types and constants for the thermistor averaging and temperature unit.
package thavg_pkg;

   localparam int N_W      = 7;   // wide enough for any supported sample count
   localparam int DVD_W    = 43;  // divider dividend and quotient width
   localparam int DVS_W    = 33;  // divider divisor width

   localparam logic [2:0] REG_FS_SEL    = 3'd0;
   localparam logic [2:0] REG_COUNT     = 3'd1;
   localparam logic [2:0] REG_BETA      = 3'd2;
   localparam logic [2:0] REG_SERIES    = 3'd3;
   localparam logic [2:0] REG_NOMINAL   = 3'd4;
   localparam logic [2:0] REG_MIN_CODE  = 3'd5;

   localparam logic [1:0] STATUS_VALID     = 2'd0;
   localparam logic [1:0] STATUS_INVALID   = 2'd1;
   localparam logic [1:0] STATUS_SATURATED = 2'd2;

   localparam logic [29:0] LN2_Q30        = 30'd744261118;
   localparam logic [15:0] OFFSET_Q24     = 16'd56371;
   localparam logic [12:0] KELVIN_OFF_16  = 13'd4368;

   typedef struct packed {
      logic        fs_sel;
      logic [4:0]  sample_count;
      logic [12:0] beta;
      logic [19:0] series_ohms;
      logic [19:0] nominal_ohms;
      logic [11:0] min_valid_code;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      fs_sel:         1'b0,
      sample_count:   5'd10,
      beta:           13'd3435,
      series_ohms:    20'd10000,
      nominal_ohms:   20'd10000,
      min_valid_code: 12'd1
   };

   typedef struct packed {
      logic [15:0]    sum;
      logic [N_W-1:0] count;
      logic           fs_sel;
   } job_type;

endpackage

[hdl/thavg_req_if.sv]
// Request channel interface carrying one converter sample.
interface thavg_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

[hdl/thavg_rsp_if.sv]
// Result channel interface carrying the average, temperature and status.
interface thavg_rsp_if;
   logic               valid;
   logic               ready;
   logic [11:0]        average_code;
   logic signed [16:0] temperature;
   logic [1:0]         status;
   modport source (output valid, output average_code, output temperature, output status,
                   input ready);
   modport sink (input valid, input average_code, input temperature, input status,
                 output ready);
endinterface

[hdl/thavg_fifo.sv]
// Two-entry job queue between the sample front end and the compute back end.
module thavg_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  thavg_pkg::job_type push_job,
   input  logic              pop,
   output thavg_pkg::job_type pop_job,
   output logic              full,
   output logic              empty
);
   thavg_pkg::job_type mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign pop_job = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

[hdl/thavg_front.sv]
// Sample front end: masks, sums and counts samples and queues finished groups.
module thavg_front #(
   parameter int SAMPLE_BITS = 12,
   parameter int MAX_SAMPLES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  thavg_pkg::cfg_type cfg,
   thavg_req_if.sink          req,
   input  logic               queue_full,
   output logic               push,
   output thavg_pkg::job_type push_job
);
   logic [15:0]               sum_ff, sum_in;
   logic [thavg_pkg::N_W-1:0] taken_ff, taken_in, count;
   logic [11:0]               mask, sample;
   logic                      accept;

   always_comb begin
      for (int i = 0; i < 12; i++) begin
         mask[i] = cfg.fs_sel ? (i < SAMPLE_BITS) : (i < 10);
      end
   end

   always_comb begin
      if (cfg.sample_count == 5'd0) begin
         count = thavg_pkg::N_W'(1);
      end else if (thavg_pkg::N_W'(cfg.sample_count) > thavg_pkg::N_W'(MAX_SAMPLES)) begin
         count = thavg_pkg::N_W'(MAX_SAMPLES);
      end else begin
         count = thavg_pkg::N_W'(cfg.sample_count);
      end
   end

   assign req.ready = ~queue_full;
   assign accept    = req.valid & ~queue_full;
   assign sample    = req.sample & mask;
   assign sum_in    = sum_ff + {4'd0, sample};
   assign taken_in  = taken_ff + thavg_pkg::N_W'(1);
   assign push      = accept && (taken_in >= count);

   assign push_job.sum    = sum_in;
   assign push_job.count  = count;
   assign push_job.fs_sel = cfg.fs_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= 16'd0;
         taken_ff <= '0;
      end else if (accept) begin
         if (push) begin
            sum_ff   <= 16'd0;
            taken_ff <= '0;
         end else begin
            sum_ff   <= sum_in;
            taken_ff <= taken_in;
         end
      end
   end
endmodule

[hdl/thavg_div.sv]
// Restoring divider, one quotient bit per cycle.
module thavg_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [thavg_pkg::DVD_W-1:0]   dividend,
   input  logic [thavg_pkg::DVS_W-1:0]   divisor,
   output logic                          done,
   output logic [thavg_pkg::DVD_W-1:0]   quotient
);
   logic [thavg_pkg::DVS_W-1:0] rem_ff, rem_in, dvs_ff;
   logic [thavg_pkg::DVD_W-1:0] dq_ff, dq_in;
   logic [5:0]                  cnt_ff;
   logic                        busy_ff, done_ff;
   logic [thavg_pkg::DVS_W:0]   shifted, diff;
   logic                        ge;

   assign shifted = {rem_ff, dq_ff[thavg_pkg::DVD_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign rem_in  = ge ? diff[thavg_pkg::DVS_W-1:0] : shifted[thavg_pkg::DVS_W-1:0];
   assign dq_in   = {dq_ff[thavg_pkg::DVD_W-2:0], ge};

   assign done     = done_ff;
   assign quotient = dq_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dq_ff  <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dq_ff  <= dq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'(thavg_pkg::DVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule

[hdl/thavg_back.sv]
// Compute back end: average, range check, four logarithms and the beta equation.
module thavg_back (
   input  logic                        clock,
   input  logic                        reset,
   input  thavg_pkg::cfg_type          cfg,
   input  thavg_pkg::job_type          job,
   input  logic                        queue_empty,
   output logic                        pop,
   thavg_rsp_if.source                 rsp,
   output logic                        div_start,
   output logic [thavg_pkg::DVD_W-1:0] div_dividend,
   output logic [thavg_pkg::DVS_W-1:0] div_divisor,
   input  logic                        div_done,
   input  logic [thavg_pkg::DVD_W-1:0] div_quotient
);
   typedef enum logic [3:0] {
      S_IDLE, S_AVG_WAIT, S_CHECK, S_LN_INIT, S_LN_SQ, S_LN_MUL, S_LN_ACC,
      S_DIV_SETUP, S_DIV_WAIT, S_DONE
   } state_type;

   state_type                   state_ff;
   logic [15:0]                 avg_ff;
   logic                        fs_sel_ff;
   logic [1:0]                  k_ff;
   logic [4:0]                  e_ff, it_ff;
   logic [30:0]                 m_ff;
   logic [23:0]                 frac_ff;
   logic [58:0]                 lnprod_ff;
   logic signed [31:0]          y_ff;
   logic signed [16:0]          temp_ff;
   logic [1:0]                  status_ff;
   logic                        div_start_ff;
   logic [thavg_pkg::DVD_W-1:0] dvd_ff;
   logic [thavg_pkg::DVS_W-1:0] dvs_ff;
   logic                        rsp_valid_ff;
   logic [11:0]                 rsp_avg_ff;
   logic signed [16:0]          rsp_temp_ff;
   logic [1:0]                  rsp_status_ff;

   logic [12:0]        fs;
   logic [19:0]        rs, rn, ln_x;
   logic [4:0]         ln_e;
   logic [61:0]        sq;
   logic [31:0]        sq_t;
   logic [59:0]        ln_round;
   logic [31:0]        ln_val;
   logic [31:0]        y_abs;
   logic               invalid;
   logic signed [44:0] t_full;

   function automatic logic [4:0] msb_index(input logic [19:0] x);
      logic [4:0] r;
      r = 5'd0;
      for (int i = 0; i < 20; i++) begin
         if (x[i]) r = 5'(i);
      end
      return r;
   endfunction

   assign fs = fs_sel_ff ? 13'd4096 : 13'd1024;
   assign rs = (cfg.series_ohms == 20'd0) ? 20'd1 : cfg.series_ohms;
   assign rn = (cfg.nominal_ohms == 20'd0) ? 20'd1 : cfg.nominal_ohms;

   always_comb begin
      case (k_ff)
         2'd0:    ln_x = rs;
         2'd1:    ln_x = {7'd0, fs - avg_ff[12:0]};
         2'd2:    ln_x = rn;
         default: ln_x = {4'd0, avg_ff};
      endcase
   end

   assign ln_e     = msb_index(ln_x);
   assign sq       = m_ff * m_ff;
   assign sq_t     = sq[61:30];
   assign ln_round = {1'b0, lnprod_ff} + 60'(1 << 29);
   assign ln_val   = {2'b00, ln_round[59:30]};
   assign y_abs    = y_ff[31] ? 32'(-y_ff) : 32'(y_ff);
   assign invalid  = (avg_ff == 16'd0) || (avg_ff < {4'd0, cfg.min_valid_code})
                  || (avg_ff >= {3'd0, fs});
   assign t_full   = (y_ff[31] ? -$signed({2'b00, div_quotient})
                               : $signed({2'b00, div_quotient}))
                   - $signed({32'd0, thavg_pkg::KELVIN_OFF_16});

   assign pop          = (state_ff == S_IDLE) && !queue_empty;
   assign div_start    = div_start_ff;
   assign div_dividend = dvd_ff;
   assign div_divisor  = dvs_ff;

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.average_code = rsp_avg_ff;
   assign rsp.temperature  = rsp_temp_ff;
   assign rsp.status       = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         if (rsp_valid_ff && rsp.ready && (state_ff != S_DONE)) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (!queue_empty) begin
                  fs_sel_ff    <= job.fs_sel;
                  dvd_ff       <= thavg_pkg::DVD_W'({job.sum, 1'b0})
                                + thavg_pkg::DVD_W'(job.count);
                  dvs_ff       <= thavg_pkg::DVS_W'({job.count, 1'b0});
                  div_start_ff <= 1'b1;
                  state_ff     <= S_AVG_WAIT;
               end
            end
            S_AVG_WAIT: begin
               if (div_done) begin
                  avg_ff   <= div_quotient[15:0];
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (invalid) begin
                  temp_ff   <= 17'sd0;
                  status_ff <= thavg_pkg::STATUS_INVALID;
                  state_ff  <= S_DONE;
               end else begin
                  y_ff     <= $signed({3'd0, 29'(cfg.beta) * 29'(thavg_pkg::OFFSET_Q24)});
                  k_ff     <= 2'd0;
                  state_ff <= S_LN_INIT;
               end
            end
            S_LN_INIT: begin
               e_ff     <= ln_e;
               m_ff     <= {11'd0, ln_x} << (5'd30 - ln_e);
               frac_ff  <= 24'd0;
               it_ff    <= 5'd24;
               state_ff <= S_LN_SQ;
            end
            S_LN_SQ: begin
               m_ff    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
               frac_ff <= {frac_ff[22:0], sq_t[31]};
               it_ff   <= it_ff - 5'd1;
               if (it_ff == 5'd1) state_ff <= S_LN_MUL;
            end
            S_LN_MUL: begin
               lnprod_ff <= {e_ff, frac_ff} * thavg_pkg::LN2_Q30;
               state_ff  <= S_LN_ACC;
            end
            S_LN_ACC: begin
               if (k_ff[1]) y_ff <= y_ff - $signed(ln_val);
               else         y_ff <= y_ff + $signed(ln_val);
               k_ff <= k_ff + 2'd1;
               state_ff <= (k_ff == 2'd3) ? S_DIV_SETUP : S_LN_INIT;
            end
            S_DIV_SETUP: begin
               if (y_ff == 32'sd0) begin
                  temp_ff   <= 17'sd65535;
                  status_ff <= thavg_pkg::STATUS_SATURATED;
                  state_ff  <= S_DONE;
               end else begin
                  dvd_ff       <= thavg_pkg::DVD_W'({cfg.beta, 29'd0})
                                + thavg_pkg::DVD_W'(y_abs);
                  dvs_ff       <= {y_abs, 1'b0};
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV_WAIT;
               end
            end
            S_DIV_WAIT: begin
               if (div_done) begin
                  if (t_full > 45'sd65535) begin
                     temp_ff   <= 17'sd65535;
                     status_ff <= thavg_pkg::STATUS_SATURATED;
                  end else if (t_full < -45'sd65536) begin
                     temp_ff   <= -17'sd65536;
                     status_ff <= thavg_pkg::STATUS_SATURATED;
                  end else begin
                     temp_ff   <= t_full[16:0];
                     status_ff <= thavg_pkg::STATUS_VALID;
                  end
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_avg_ff    <= avg_ff[11:0];
                  rsp_temp_ff   <= temp_ff;
                  rsp_status_ff <= status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == thavg_pkg::STATUS_INVALID) |-> rsp_temp_ff == 17'sd0)
      else $error("invalid reading with nonzero temperature");
   a_start_wait: assert property (@(posedge clock) disable iff (reset)
      div_start_ff |-> (state_ff == S_AVG_WAIT) || (state_ff == S_DIV_WAIT))
      else $error("divider started outside a wait state");
   a_mul_after_sq: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LN_MUL) |-> ($past(state_ff) == S_LN_SQ) && ($past(it_ff) == 5'd1))
      else $error("logarithm multiply entered before all squaring rounds");
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result valid right after reset");
`endif
endmodule

[hdl/thermistor_average_to_temperature_unit.sv]
// Top level: thermistor sample averaging and beta-equation temperature unit.
// Requests that do not close a group are accepted one per cycle while the two-entry job
// queue has room. A group's result is computed in order by an average division, four
// logarithms and a quotient division. The back end works on one group at a time, sharing
// one divider and one squarer, and takes the next group once the last result is registered.
// Synchronous active-high reset clears the sums, queue, sequencer and registers to defaults.
module thermistor_average_to_temperature_unit #(
   parameter int SAMPLE_BITS = 12,
   parameter int MAX_SAMPLES = 16
) (
   input  logic        clock,
   input  logic        reset,
   thavg_req_if.sink   req_chan,
   thavg_rsp_if.source rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   // Configuration registers, one word each at byte address four times the index.
   thavg_pkg::cfg_type cfg_ff;
   logic [2:0]         csr_index;
   logic               csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= thavg_pkg::CFG_RESET;
      end else if (csr_write) begin
         case (csr_index)
            thavg_pkg::REG_FS_SEL:   cfg_ff.fs_sel         <= csr_pwdata[0];
            thavg_pkg::REG_COUNT:    cfg_ff.sample_count   <= csr_pwdata[4:0];
            thavg_pkg::REG_BETA:     cfg_ff.beta           <= csr_pwdata[12:0];
            thavg_pkg::REG_SERIES:   cfg_ff.series_ohms    <= csr_pwdata[19:0];
            thavg_pkg::REG_NOMINAL:  cfg_ff.nominal_ohms   <= csr_pwdata[19:0];
            thavg_pkg::REG_MIN_CODE: cfg_ff.min_valid_code <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         thavg_pkg::REG_FS_SEL:   csr_prdata = {31'd0, cfg_ff.fs_sel};
         thavg_pkg::REG_COUNT:    csr_prdata = {27'd0, cfg_ff.sample_count};
         thavg_pkg::REG_BETA:     csr_prdata = {19'd0, cfg_ff.beta};
         thavg_pkg::REG_SERIES:   csr_prdata = {12'd0, cfg_ff.series_ohms};
         thavg_pkg::REG_NOMINAL:  csr_prdata = {12'd0, cfg_ff.nominal_ohms};
         thavg_pkg::REG_MIN_CODE: csr_prdata = {20'd0, cfg_ff.min_valid_code};
         default:                 csr_prdata = 32'd0;
      endcase
   end

   // The front end sums samples and hands each finished group to the queue.
   logic               push, pop, queue_full, queue_empty;
   thavg_pkg::job_type push_job, pop_job;

   thavg_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   thavg_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   // The back end sequences the math, sharing one divider for both divisions.
   logic                        div_start, div_done;
   logic [thavg_pkg::DVD_W-1:0] div_dividend, div_quotient;
   logic [thavg_pkg::DVS_W-1:0] div_divisor;

   thavg_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .job          (pop_job),
      .queue_empty  (queue_empty),
      .pop          (pop),
      .rsp          (rsp_chan),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

   thavg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );
endmodule

[bench/tb_thermistor_average_to_temperature_unit.sv]
// Testbench for the thermistor averaging and beta-equation temperature unit.
`timescale 1ns / 1ps

// Keeps its own copy of the registers and the running sum, and queues the expected
// reading for every request that closes a group.
class reading_board;
   typedef struct {
      logic [11:0] average_code;
      logic [16:0] temperature;
      logic [1:0]  status;
   } reading_type;

   thavg_pkg::cfg_type cfg;
   logic [15:0]        sum;
   int unsigned        taken;
   reading_type        readings[$];
   int                 errors;

   function void clear();
      cfg      = thavg_pkg::CFG_RESET;
      sum      = '0;
      taken    = 0;
      errors   = 0;
      readings = {};
   endfunction

   function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
         thavg_pkg::REG_FS_SEL:   cfg.fs_sel         = value[0];
         thavg_pkg::REG_COUNT:    cfg.sample_count   = value[4:0];
         thavg_pkg::REG_BETA:     cfg.beta           = value[12:0];
         thavg_pkg::REG_SERIES:   cfg.series_ohms    = value[19:0];
         thavg_pkg::REG_NOMINAL:  cfg.nominal_ohms   = value[19:0];
         thavg_pkg::REG_MIN_CODE: cfg.min_valid_code = value[11:0];
         default: ;
      endcase
   endfunction

   // Natural logarithm in Q24 via log2: msb index plus 24 squaring rounds.
   function longint unsigned log_q24(longint unsigned x);
      longint unsigned mant, frac;
      int              msb;
      frac = 0;
      if (x == 0) x = 1;
      msb = 0;
      while (msb < 31 && (x >> (msb + 1)) != 0) msb++;
      mant = x << (30 - msb);
      for (int i = 23; i >= 0; i--) begin
         mant = (mant * mant) >> 30;
         if (mant >= (64'd1 << 31)) begin
            mant = mant >> 1;
            frac |= 64'd1 << i;
         end
      end
      frac |= longint'(msb) << 24;
      return (frac * thavg_pkg::LN2_Q30 + (64'd1 << 29)) >> 30;
   endfunction

   function void note_sample(logic [11:0] raw);
      int unsigned     n, fs, s, avg;
      longint          y, temp;
      longint unsigned num, den, quo, rs, rn;
      reading_type     r;
      n = cfg.sample_count;
      if (n == 0) n = 1;
      if (n > 16) n = 16;
      fs = cfg.fs_sel ? 4096 : 1024;
      s  = cfg.fs_sel ? raw : raw[9:0];
      sum = sum + s[15:0];
      taken++;
      if (taken < n) return;
      avg   = (2 * sum + n) / (2 * n);
      sum   = '0;
      taken = 0;
      temp  = 0;
      r.status = thavg_pkg::STATUS_VALID;
      if (avg == 0 || avg < cfg.min_valid_code || avg >= fs) begin
         r.status = thavg_pkg::STATUS_INVALID;
      end else begin
         rs = (cfg.series_ohms == 0) ? 1 : cfg.series_ohms;
         rn = (cfg.nominal_ohms == 0) ? 1 : cfg.nominal_ohms;
         y = longint'(log_q24(rs)) + longint'(log_q24(fs - avg))
             - longint'(log_q24(rn)) - longint'(log_q24(avg))
             + longint'(cfg.beta) * thavg_pkg::OFFSET_Q24;
         if (y == 0) begin
            temp = 65535;
            r.status = thavg_pkg::STATUS_SATURATED;
         end else begin
            num  = (longint'(cfg.beta) * 16) << 24;
            den  = (y < 0) ? -y : y;
            quo  = (2 * num + den) / (2 * den);
            temp = (y < 0) ? -longint'(quo) : longint'(quo);
            temp -= thavg_pkg::KELVIN_OFF_16;
            if (temp > 65535) begin
               temp = 65535;
               r.status = thavg_pkg::STATUS_SATURATED;
            end
            if (temp < -65536) begin
               temp = -65536;
               r.status = thavg_pkg::STATUS_SATURATED;
            end
         end
      end
      r.average_code = avg[11:0];
      r.temperature  = temp[16:0];
      readings.push_back(r);
   endfunction

   function void check_result(logic [11:0] avg, logic [16:0] temp, logic [1:0] status);
      reading_type r;
      if (readings.size() == 0) begin
         errors++;
         if (errors <= 10) $display("Unexpected result: avg %0d temp %0d status %0d",
                                    avg, $signed(temp), status);
         return;
      end
      r = readings.pop_front();
      if (avg !== r.average_code || temp !== r.temperature || status !== r.status) begin
         errors++;
         if (errors <= 10)
            $display("Mismatch: expected avg %0d temp %0d status %0d, got %0d %0d %0d",
                     r.average_code, $signed(r.temperature), r.status,
                     avg, $signed(temp), status);
      end
   endfunction
endclass

module tb_thermistor_average_to_temperature_unit;
   localparam longint CYCLE_LIMIT = 4000000;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   thavg_req_if req_chan ();
   thavg_rsp_if rsp_chan ();

   thermistor_average_to_temperature_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan.sink),
      .rsp_chan    (rsp_chan.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   reading_board board;
   int           sender_idle_pct;   // chance in percent that the sender skips a cycle
   int           receiver_idle_pct; // chance in percent that the receiver stalls a cycle
   int           hold_off;          // cycles the receiver still refuses results
   longint       cycles;
   int           sent;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Cycle counter: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // The receiver drives ready at the falling edge. A long hold-off is counted down
   // here so the block fills its job queue and stalls its request side.
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   // Results are taken at the rising edge at which valid and ready are both high.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         board.check_result(rsp_chan.average_code, rsp_chan.temperature, rsp_chan.status);
   end

   // One APB write: setup cycle, then access cycle. Called at a falling edge.
   task automatic write_csr(logic [2:0] idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.write_reg(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_all(logic fs, logic [4:0] count, logic [12:0] beta,
                            logic [19:0] series, logic [19:0] nominal, logic [11:0] min_code);
      write_csr(thavg_pkg::REG_FS_SEL, fs);
      write_csr(thavg_pkg::REG_COUNT, count);
      write_csr(thavg_pkg::REG_BETA, beta);
      write_csr(thavg_pkg::REG_SERIES, series);
      write_csr(thavg_pkg::REG_NOMINAL, nominal);
      write_csr(thavg_pkg::REG_MIN_CODE, min_code);
   endtask

   // Offers one request, with random gaps in front, and waits for it to be taken.
   // Valid is left high so back-to-back requests need no second assignment.
   task automatic send_sample(logic [11:0] s);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.sample <= s;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      board.note_sample(s);
      sent++;
      @(negedge clock);
   endtask

   // Waits until every queued reading has come back, then keeps idling
   // so that no partly computed group remains before the next write.
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (board.readings.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   // Random requests: mostly groups around one level so averages land in range,
   // the rest anywhere in the code space. Bits the block ignores still toggle.
   task automatic send_random(int count);
      int          level, fs, v;
      logic [11:0] s;
      level = 0;
      for (int k = 0; k < count; k++) begin
         fs = board.cfg.fs_sel ? 4096 : 1024;
         if ($urandom_range(0, 9) == 0 || k == 0) level = $urandom_range(0, fs - 1);
         if ($urandom_range(0, 99) < 75) begin
            v = level + $urandom_range(0, 14) - 7;
            if (v < 0) v = 0;
            if (v > fs - 1) v = fs - 1;
            s = v;
            if (!board.cfg.fs_sel) s[11:10] = $urandom_range(0, 3);
         end else begin
            s = $urandom_range(0, 4095);
         end
         send_sample(s);
      end
   endtask

   initial begin
      board = new();
      board.clear();
      reset             = 1'b1;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      req_chan.valid    = 1'b0;
      req_chan.sample   = '0;
      rsp_chan.ready    = 1'b0;
      hold_off          = 0;
      cycles            = 0;
      sent              = 0;
      sender_idle_pct   = 23;
      receiver_idle_pct = 75;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. Reset settings first: one group of ten at mid scale.
      repeat (10) send_sample(12'd512);
      settle();
      // Single-sample groups in 10-bit mode: zero average, the floor, the top code,
      // and codes whose upper bits are ignored.
      write_csr(thavg_pkg::REG_COUNT, 5'd1);
      send_sample(12'd0);
      send_sample(12'd1);
      send_sample(12'd1023);
      send_sample(12'd1024);
      send_sample(12'd4095);
      settle();
      // 12-bit mode with the floor at its top: everything but the top code is invalid.
      write_all(1'b1, 5'd0, 13'd6000, 20'd1000000, 20'd100, 12'd4095);
      send_sample(12'd4094);
      send_sample(12'd4095);
      settle();
      write_csr(thavg_pkg::REG_MIN_CODE, 12'd0);
      send_sample(12'd0);
      send_sample(12'd2);
      send_sample(12'd4094);
      settle();
      // Negative denominator: tiny series resistor, huge nominal, zero register as one.
      write_all(1'b1, 5'd1, 13'd1000, 20'd0, 20'hFFFFF, 12'd1);
      send_sample(12'd4095);
      send_sample(12'd1);
      settle();
      write_csr(thavg_pkg::REG_BETA, 13'd0);
      send_sample(12'd2048);
      settle();
      // Count lowered while a group is open: the next request closes it.
      write_all(1'b0, 5'd16, 13'd3435, 20'd10000, 20'd0, 12'd1);
      repeat (7) send_sample(12'd1023);
      settle();
      write_csr(thavg_pkg::REG_COUNT, 5'd3);
      send_sample(12'd700);
      settle();

      // Random part in three idling regimes, several settings each.
      for (int phase = 0; phase < 10; phase++) begin
         if (phase == 3) begin
            sender_idle_pct   = 75;
            receiver_idle_pct = 23;
         end else if (phase == 6) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         case (phase)
            0: write_all(1'b0, 5'd16, 13'd6000, 20'd1000000, 20'd100, 12'd0);
            1: write_all(1'b1, 5'd31, 13'd1000, 20'd100, 20'd1000000, 12'd4095);
            2: write_all(1'b1, 5'd1, 13'hFFF, 20'hFFFFF, 20'd1, 12'd2);
            3: write_all(1'b0, 5'd0, 13'd3435, 20'd10000, 20'd10000, 12'd1);
            default: write_all($urandom_range(0, 1), $urandom_range(0, 31),
                               $urandom_range(1000, 6000), $urandom_range(100, 1000000),
                               $urandom_range(100, 1000000), $urandom_range(0, 8));
         endcase
         // Once, the receiver refuses results for a long stretch while requests keep coming.
         if (phase == 7) hold_off = 3000;
         send_random(125);
         settle();
      end

      if (board.errors == 0 && board.readings.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

[thermistor_average_to_temperature_unit.f]
hdl/thavg_pkg.sv
hdl/thavg_req_if.sv
hdl/thavg_rsp_if.sv
hdl/thavg_fifo.sv
hdl/thavg_front.sv
hdl/thavg_div.sv
hdl/thavg_back.sv
hdl/thermistor_average_to_temperature_unit.sv
bench/tb_thermistor_average_to_temperature_unit.sv
